>>> design/euq_pkg.sv
// Shared types, constants and fixed-point helpers for the Euler-to-quaternion pipeline.
// No dependencies; used by every module under design/.
`default_nettype none
package euq_pkg;
  localparam int QW = 34;                 // Q30 working word, signed
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int MAX_STAGES = 24;
  localparam int OUT_W = 16;

  typedef logic signed [QW-1:0] q30_t;

  localparam q30_t Q30_ONE     = 34'sd1073741824;
  localparam q30_t Q30_PI      = 34'sd3373259426;
  localparam q30_t Q30_HALF_PI = 34'sd1686629713;
  localparam q30_t INV_GAIN    = 34'sd652032874;

  // which component takes s/2
  localparam logic [1:0] SEL_TRACE = 2'd0;
  localparam logic [1:0] SEL_X     = 2'd1;
  localparam logic [1:0] SEL_Y     = 2'd2;
  localparam logic [1:0] SEL_Z     = 2'd3;

  typedef struct packed {
    logic [1:0] sel;
    q30_t       ta;
    q30_t       tb;
    q30_t       tc;
  } euq_side_t;

  function automatic q30_t atan_q30(input int i);
    q30_t v;
    case (i)
      0:  v = 34'sd843314857;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043837;
      3:  v = 34'sd133525159;
      4:  v = 34'sd67021687;
      5:  v = 34'sd33543516;
      6:  v = 34'sd16775851;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194283;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048576;
      11: v = 34'sd524288;
      12: v = 34'sd262144;
      13: v = 34'sd131072;
      14: v = 34'sd65536;
      15: v = 34'sd32768;
      16: v = 34'sd16384;
      17: v = 34'sd8192;
      18: v = 34'sd4096;
      19: v = 34'sd2048;
      20: v = 34'sd1024;
      21: v = 34'sd512;
      22: v = 34'sd256;
      23: v = 34'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Q30 product, round half up
  function automatic q30_t qmul(input q30_t a, input q30_t b);
    logic signed [2*QW-1:0] p;
    p = $signed(a) * $signed(b) + $signed((2*QW)'(64'd536870912));
    return q30_t'(p >>> 30);
  endfunction

  // Q30 -> Q2.14 with rounding and saturation to +-1.0
  function automatic logic signed [OUT_W-1:0] to_out(input q30_t q);
    q30_t                   t;
    logic signed [QW-17:0]  r;
    logic signed [OUT_W-1:0] o;
    t = q + 34'sd32768;
    r = (QW-16)'(t >>> 16);
    if (r > 18'sd16384) o = 16'sd16384;
    else if (r < -18'sd16384) o = -16'sd16384;
    else o = OUT_W'(r);
    return o;
  endfunction
endpackage
`default_nettype wire

>>> design/euq_cordic.sv
// Pipelined rotation-mode CORDIC, one iteration per register stage.
// Depends on euq_pkg (q30_t, atan table, start gain).
`default_nettype none
module euq_cordic #(
  parameter int STAGES = 16
) (
  input  wire              clk,
  input  wire              en,
  input  euq_pkg::q30_t    ang,
  input  wire              neg,
  output euq_pkg::q30_t    sin_o,
  output euq_pkg::q30_t    cos_o
);
  import euq_pkg::*;

  q30_t x_r [STAGES];
  q30_t y_r [STAGES];
  q30_t z_r [STAGES];
  logic neg_r [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_it
    q30_t x_i, y_i, z_i, x_o, y_o, z_o;
    logic n_i;
    if (k == 0) begin : g_first
      assign x_i = INV_GAIN;
      assign y_i = '0;
      assign z_i = ang;
      assign n_i = neg;
    end else begin : g_next
      assign x_i = x_r[k-1];
      assign y_i = y_r[k-1];
      assign z_i = z_r[k-1];
      assign n_i = neg_r[k-1];
    end
    always_comb begin
      if (!z_i[QW-1]) begin
        x_o = x_i - (y_i >>> k);
        y_o = y_i + (x_i >>> k);
        z_o = z_i - atan_q30(k);
      end else begin
        x_o = x_i + (y_i >>> k);
        y_o = y_i - (x_i >>> k);
        z_o = z_i + atan_q30(k);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]   <= x_o;
        y_r[k]   <= y_o;
        z_r[k]   <= z_o;
        neg_r[k] <= n_i;
      end
    end
  end

  // undo the half-turn fold
  assign cos_o = neg_r[STAGES-1] ? -x_r[STAGES-1] : x_r[STAGES-1];
  assign sin_o = neg_r[STAGES-1] ? -y_r[STAGES-1] : y_r[STAGES-1];
endmodule
`default_nettype wire

>>> design/euq_root.sv
// Pipelined s = sqrt(v), floored at 0.5, then r = floor(2^59 / s); one bit per stage.
// Depends on euq_pkg (q30_t, euq_side_t).
`default_nettype none
module euq_root (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 en,
  input  wire                 in_valid,
  input  euq_pkg::q30_t       v,
  input  euq_pkg::euq_side_t  side,
  output logic                out_valid,
  output logic [31:0]         s_o,
  output logic [30:0]         r_o,
  output euq_pkg::euq_side_t  side_o
);
  import euq_pkg::*;

  localparam int SQ_N = 32;
  localparam int DV_N = 31;

  logic [63:0] n_r   [SQ_N];
  logic [63:0] res_r [SQ_N];
  euq_side_t   sqs_r [SQ_N];
  logic [SQ_N-1:0] sq_v_r;

  logic [32:0] rem_r [DV_N];
  logic [31:0] ds_r  [DV_N];
  logic [30:0] q_r   [DV_N];
  euq_side_t   dss_r [DV_N];
  logic [DV_N-1:0] dv_v_r;

  logic [63:0] n0;
  logic [31:0] s_fl;

  assign n0 = v[QW-1] || (v == '0) ? 64'd0 : (64'(v) << 30);

  for (genvar k = 0; k < SQ_N; k++) begin : g_sq
    localparam logic [63:0] BITC = 64'd1 << (62 - 2*k);
    logic [63:0] n_i, res_i, n_o, res_o, trial;
    euq_side_t   sd_i;
    if (k == 0) begin : g_first
      assign n_i   = n0;
      assign res_i = '0;
      assign sd_i  = side;
    end else begin : g_next
      assign n_i   = n_r[k-1];
      assign res_i = res_r[k-1];
      assign sd_i  = sqs_r[k-1];
    end
    always_comb begin
      trial = res_i + BITC;
      if (n_i >= trial) begin
        n_o   = n_i - trial;
        res_o = (res_i >> 1) + BITC;
      end else begin
        n_o   = n_i;
        res_o = res_i >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k]   <= n_o;
        res_r[k] <= res_o;
        sqs_r[k] <= sd_i;
      end
    end
  end

  assign s_fl = (res_r[SQ_N-1] < 64'd536870912) ? 32'd536870912 : res_r[SQ_N-1][31:0];

  for (genvar k = 0; k < DV_N; k++) begin : g_dv
    logic [32:0] rem_i, rem_o;
    logic [33:0] sh;
    logic [31:0] s_i;
    logic [30:0] q_i, q_o;
    euq_side_t   sd_i;
    if (k == 0) begin : g_first
      assign rem_i = 33'd268435456;   // 2^59 >> 31
      assign s_i   = s_fl;
      assign q_i   = '0;
      assign sd_i  = sqs_r[SQ_N-1];
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign s_i   = ds_r[k-1];
      assign q_i   = q_r[k-1];
      assign sd_i  = dss_r[k-1];
    end
    always_comb begin
      sh = {rem_i, 1'b0};
      if (sh >= {2'b00, s_i}) begin
        rem_o = 33'(sh - {2'b00, s_i});
        q_o   = {q_i[29:0], 1'b1};
      end else begin
        rem_o = sh[32:0];
        q_o   = {q_i[29:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_o;
        ds_r[k]  <= s_i;
        q_r[k]   <= q_o;
        dss_r[k] <= sd_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= '0;
      dv_v_r <= '0;
    end else if (en) begin
      sq_v_r <= {sq_v_r[SQ_N-2:0], in_valid};
      dv_v_r <= {dv_v_r[DV_N-2:0], sq_v_r[SQ_N-1]};
    end
  end

  assign out_valid = dv_v_r[DV_N-1];
  assign s_o       = ds_r[DV_N-1];
  assign r_o       = q_r[DV_N-1];
  assign side_o    = dss_r[DV_N-1];
endmodule
`default_nettype wire

>>> design/euler_to_quaternion.sv
// Top level: Euler ZYX angles to unit quaternion, fully pipelined stream block.
// Depends on euq_pkg, euq_cordic and euq_root.
//
// Takes roll, pitch, yaw (signed Q3.13 radians) and returns x, y, z, w (signed
// Q2.14, saturated to +-1.0). One beat is accepted every cycle while the pipe is
// not held. Each beat passes angle fold, CORDIC, matrix, branch select, square
// root, reciprocal, final products and output register in that order; the
// bit-per-stage root and divider make up most of the pipe. A two-entry output
// (register plus skid) keeps the input open while one result waits; the whole
// pipe holds only when both are full. No state carries between beats.
`default_nettype none
module euler_to_quaternion #(
  parameter int CORDIC_STAGES = euq_pkg::CORDIC_STAGES_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [47:0] in_tdata,   // roll_angle[15:0], pitch_angle[31:16], yaw_angle[47:32]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [63:0] out_tdata   // quat_x[15:0], quat_y[31:16], quat_z[47:32], quat_w[63:48]
);
  import euq_pkg::*;

  function automatic q30_t fold(input logic signed [15:0] ang, output logic neg);
    q30_t a;
    a = q30_t'(ang) <<< 17;
    neg = 1'b0;
    if (a > Q30_HALF_PI) begin
      a = a - Q30_PI;
      neg = 1'b1;
    end else if (a < -Q30_HALF_PI) begin
      a = a + Q30_PI;
      neg = 1'b1;
    end
    return a;
  endfunction

  logic en;
  logic skid_v_r, out_v_r;
  logic [63:0] skid_r, out_r;

  assign en        = !skid_v_r;
  assign in_tready = en;

  // stage 1: angle fold
  logic s1_v_r;
  q30_t ang_r [3];
  logic neg_r [3];
  q30_t ang_nxt [3];
  logic neg_nxt [3];

  always_comb begin
    ang_nxt[0] = fold($signed(in_tdata[15:0]),  neg_nxt[0]);
    ang_nxt[1] = fold($signed(in_tdata[31:16]), neg_nxt[1]);
    ang_nxt[2] = fold($signed(in_tdata[47:32]), neg_nxt[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        ang_r[l] <= ang_nxt[l];
        neg_r[l] <= neg_nxt[l];
      end
    end
  end

  // CORDIC lanes: 0 roll, 1 pitch, 2 yaw
  q30_t sn [3];
  q30_t cs [3];
  logic [CORDIC_STAGES-1:0] cv_r;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    euq_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
      .clk   (clk),
      .en    (en),
      .ang   (ang_r[l]),
      .neg   (neg_r[l]),
      .sin_o (sn[l]),
      .cos_o (cs[l])
    );
  end

  // matrix, first products
  logic m1_v_r;
  q30_t cysp_r, sysp_r, m00a_r, sycr_r, sysr_r, m10a_r, cycr_r, cysr_r, m21a_r, m22a_r;
  q30_t sr_r, cr_r, sp_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cysp_r <= qmul(cs[2], sn[1]);
      sysp_r <= qmul(sn[2], sn[1]);
      m00a_r <= qmul(cs[2], cs[1]);
      sycr_r <= qmul(sn[2], cs[0]);
      sysr_r <= qmul(sn[2], sn[0]);
      m10a_r <= qmul(sn[2], cs[1]);
      cycr_r <= qmul(cs[2], cs[0]);
      cysr_r <= qmul(cs[2], sn[0]);
      m21a_r <= qmul(cs[1], sn[0]);
      m22a_r <= qmul(cs[1], cs[0]);
      sr_r   <= sn[0];
      cr_r   <= cs[0];
      sp_r   <= sn[1];
    end
  end

  // matrix, second products
  logic m2_v_r;
  q30_t m00_r, m01_r, m02_r, m10_r, m11_r, m12_r, m20_r, m21_r, m22_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m00_r <= m00a_r;
      m01_r <= qmul(cysp_r, sr_r) - sycr_r;
      m02_r <= qmul(cysp_r, cr_r) + sysr_r;
      m10_r <= m10a_r;
      m11_r <= qmul(sysp_r, sr_r) + cycr_r;
      m12_r <= qmul(sysp_r, cr_r) - cysr_r;
      m20_r <= -sp_r;
      m21_r <= m21a_r;
      m22_r <= m22a_r;
    end
  end

  // branch select: trace or largest diagonal
  logic      b_v_r;
  q30_t      v_r, v_nxt, tr;
  euq_side_t side_r, side_nxt;

  always_comb begin
    tr = m00_r + m11_r + m22_r;
    if (!tr[QW-1] && (tr != '0)) begin
      side_nxt.sel = SEL_TRACE;
      v_nxt        = tr + Q30_ONE;
      side_nxt.ta  = m21_r - m12_r;
      side_nxt.tb  = m02_r - m20_r;
      side_nxt.tc  = m10_r - m01_r;
    end else if ((m22_r > m11_r) && (m22_r > m00_r)) begin
      side_nxt.sel = SEL_Z;
      v_nxt        = m22_r - m00_r - m11_r + Q30_ONE;
      side_nxt.ta  = m10_r - m01_r;
      side_nxt.tb  = m02_r + m20_r;
      side_nxt.tc  = m12_r + m21_r;
    end else if (m11_r > m00_r) begin
      side_nxt.sel = SEL_Y;
      v_nxt        = m11_r - m22_r - m00_r + Q30_ONE;
      side_nxt.ta  = m02_r - m20_r;
      side_nxt.tb  = m21_r + m12_r;
      side_nxt.tc  = m01_r + m10_r;
    end else begin
      side_nxt.sel = SEL_X;
      v_nxt        = m00_r - m11_r - m22_r + Q30_ONE;
      side_nxt.ta  = m21_r - m12_r;
      side_nxt.tb  = m10_r + m01_r;
      side_nxt.tc  = m20_r + m02_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r    <= v_nxt;
      side_r <= side_nxt;
    end
  end

  // square root and reciprocal
  logic        rt_v;
  logic [31:0] rt_s;
  logic [30:0] rt_r;
  euq_side_t   rt_side;

  euq_root u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (b_v_r),
    .v         (v_r),
    .side      (side_r),
    .out_valid (rt_v),
    .s_o       (rt_s),
    .r_o       (rt_r),
    .side_o    (rt_side)
  );

  // final products
  logic       p_v_r;
  q30_t       pa_r, pb_r, pc_r, ph_r;
  logic [1:0] psel_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r   <= qmul(rt_side.ta, q30_t'(rt_r));
      pb_r   <= qmul(rt_side.tb, q30_t'(rt_r));
      pc_r   <= qmul(rt_side.tc, q30_t'(rt_r));
      ph_r   <= q30_t'(rt_s >> 1);
      psel_r <= rt_side.sel;
    end
  end

  // place components
  q30_t qx, qy, qz, qw;
  logic [63:0] res;

  always_comb begin
    case (psel_r)
      SEL_TRACE: begin qx = pa_r; qy = pb_r; qz = pc_r; qw = ph_r; end
      SEL_X:     begin qx = ph_r; qw = pa_r; qy = pb_r; qz = pc_r; end
      SEL_Y:     begin qy = ph_r; qw = pa_r; qz = pb_r; qx = pc_r; end
      default:   begin qz = ph_r; qw = pa_r; qx = pb_r; qy = pc_r; end
    endcase
    res = {to_out(qw), to_out(qz), to_out(qy), to_out(qx)};
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      cv_r   <= '0;
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
      b_v_r  <= 1'b0;
      p_v_r  <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid;
      cv_r   <= {cv_r[CORDIC_STAGES-2:0], s1_v_r};
      m1_v_r <= cv_r[CORDIC_STAGES-1];
      m2_v_r <= m1_v_r;
      b_v_r  <= m2_v_r;
      p_v_r  <= rt_v;
    end
  end

  // output register plus skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_tready) skid_v_r <= 1'b0;
    end else if (out_v_r && !out_tready) begin
      if (p_v_r) skid_v_r <= 1'b1;
    end else begin
      out_v_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_tready) out_r <= skid_r;
    end else if (out_v_r && !out_tready) begin
      if (p_v_r) skid_r <= res;
    end else if (p_v_r) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

  // skid only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a beat with output register empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !out_tready) |=> (skid_v_r && out_v_r))
    else $error("skid beat lost while stalled");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ($signed(out_r[15:0]) <= 16'sd16384 && $signed(out_r[15:0]) >= -16'sd16384 &&
                 $signed(out_r[63:48]) <= 16'sd16384 && $signed(out_r[63:48]) >= -16'sd16384))
    else $error("quaternion component beyond saturation limit");
endmodule
`default_nettype wire

>>> bench/euler_to_quaternion_tb.sv
// Self-checking bench for euler_to_quaternion: Euler ZYX angles in, quaternion out.
// Depends on euq_pkg and the euler_to_quaternion RTL; directed table, then random beats.
`default_nettype none
module euler_to_quaternion_tb;
  import euq_pkg::*;

  localparam int N_RANDOM  = 1250;
  localparam int LATENCY   = CORDIC_STAGES_DEF + 69;
  localparam int WDOG_LIMIT = 4 * LATENCY + 400;

  typedef struct packed {
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
  } attitude_t;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } quat_t;

  // directed row: angles, plus a typed-in quaternion when it is obvious
  typedef struct {
    attitude_t a;
    bit        has_q;
    quat_t     q;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;

  quat_t quat_queue[$];
  int    n_fail;
  int    idle_cycles;

  euler_to_quaternion uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: Q30 math in 64-bit words, same rounding as the block.
  // ---------------------------------------------------------------------------
  function automatic longint q30_mul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint atan_step(int i);
    longint t[24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                      33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
                      524288, 262144, 131072, 65536, 32768, 16384, 8192, 4096,
                      2048, 1024, 512, 256, 128};
    return t[i];
  endfunction

  function automatic void angle_sincos(input longint ang, output longint sn,
                                       output longint cs);
    longint a, x, y, z, dx, dy;
    bit     flip;
    a = ang;
    flip = 0;
    // fold beyond a quarter turn, sign of sin/cos flips
    if (a > 64'sd1686629713) begin
      a = a - 64'sd3373259426;
      flip = 1;
    end else if (a < -64'sd1686629713) begin
      a = a + 64'sd3373259426;
      flip = 1;
    end
    x = 64'sd652032874;
    y = 0;
    z = a;
    for (int i = 0; i < CORDIC_STAGES_DEF && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_step(i);
      end else begin
        x = x + dx; y = y - dy; z = z + atan_step(i);
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic longint q30_sqrt(longint v);
    longint unsigned n, res, b;
    if (v <= 0) return 0;
    n = longint'(v) << 30;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  function automatic logic signed [15:0] q30_to_q14(longint q);
    longint r;
    r = (q + 64'sd32768) >>> 16;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return 16'(r);
  endfunction

  function automatic quat_t attitude_to_quat(attitude_t a);
    longint sr, cr, sp, cp, sy, cy, cysp, sysp, t, s, r, w;
    longint m[3][3];
    longint q[3];
    int     i, j, k;
    quat_t  o;
    angle_sincos(longint'(a.roll) * 131072, sr, cr);
    angle_sincos(longint'(a.pitch) * 131072, sp, cp);
    angle_sincos(longint'(a.yaw) * 131072, sy, cy);
    cysp = q30_mul(cy, sp);
    sysp = q30_mul(sy, sp);
    m[0][0] = q30_mul(cy, cp);
    m[0][1] = q30_mul(cysp, sr) - q30_mul(sy, cr);
    m[0][2] = q30_mul(cysp, cr) + q30_mul(sy, sr);
    m[1][0] = q30_mul(sy, cp);
    m[1][1] = q30_mul(sysp, sr) + q30_mul(cy, cr);
    m[1][2] = q30_mul(sysp, cr) - q30_mul(cy, sr);
    m[2][0] = -sp;
    m[2][1] = q30_mul(cp, sr);
    m[2][2] = q30_mul(cp, cr);
    t = m[0][0] + m[1][1] + m[2][2];
    if (t > 0) begin
      s = q30_sqrt(t + 64'sd1073741824);
      if (s < (64'sd1 <<< 29)) s = 64'sd1 <<< 29;
      r = longint'((64'd1 << 59) / longint'(s));
      w = s >>> 1;
      q[0] = q30_mul(m[2][1] - m[1][2], r);
      q[1] = q30_mul(m[0][2] - m[2][0], r);
      q[2] = q30_mul(m[1][0] - m[0][1], r);
    end else begin
      // largest diagonal; ties keep the lower index
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      s = q30_sqrt(m[i][i] - m[j][j] - m[k][k] + 64'sd1073741824);
      // degenerate root floored at one half
      if (s < (64'sd1 <<< 29)) s = 64'sd1 <<< 29;
      r = longint'((64'd1 << 59) / longint'(s));
      q[i] = s >>> 1;
      w    = q30_mul(m[k][j] - m[j][k], r);
      q[j] = q30_mul(m[j][i] + m[i][j], r);
      q[k] = q30_mul(m[k][i] + m[i][k], r);
    end
    o.x = q30_to_q14(q[0]);
    o.y = q30_to_q14(q[1]);
    o.z = q30_to_q14(q[2]);
    o.w = q30_to_q14(w);
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one beat per call, random gap first.
  // ---------------------------------------------------------------------------
  task automatic send_attitude(input attitude_t a, input bit has_q, input quat_t q);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= a;
    do @(posedge clk); while (!in_tready);
    if (has_q) quat_queue.push_back(q);
    else quat_queue.push_back(attitude_to_quat(a));
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall per beat, field-by-field compare.
  // ---------------------------------------------------------------------------
  initial begin : result_side
    int    stall;
    quat_t got, exp_q;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = out_tdata;
      if (quat_queue.size() == 0) begin
        $error("unexpected beat: out_tdata=%h", out_tdata);
        n_fail++;
      end else begin
        exp_q = quat_queue.pop_front();
        if (got.x !== exp_q.x) begin
          $error("quat_x exp %0d got %0d", exp_q.x, got.x); n_fail++;
        end
        if (got.y !== exp_q.y) begin
          $error("quat_y exp %0d got %0d", exp_q.y, got.y); n_fail++;
        end
        if (got.z !== exp_q.z) begin
          $error("quat_z exp %0d got %0d", exp_q.z, got.z); n_fail++;
        end
        if (got.w !== exp_q.w) begin
          $error("quat_w exp %0d got %0d", exp_q.w, got.w); n_fail++;
        end
      end
    end
  end

  // watchdog: cycles with no beat accepted on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed table, then random attitudes, then drain.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t  dir_rows[$];
    attitude_t a;
    quat_t     none_q;
    int        pick;
    logic signed [15:0] angs[3];

    n_fail = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    none_q = '0;

    // zero attitude gives the identity quaternion (w = 1.0)
    dir_rows.push_back('{'{16'sd0, 16'sd0, 16'sd0}, 1, '{16'sd16384, 16'sd0, 16'sd0, 16'sd0}});
    // field extremes: +-4 rad, just beyond pi and quarter-turn folding
    foreach (angs[n]) angs[n] = 0;
    for (int f = 0; f < 3; f++) begin
      foreach (angs[n]) angs[n] = 0;
      angs[f] = 16'sh7FFF;
      dir_rows.push_back('{'{angs[2], angs[1], angs[0]}, 0, none_q});
      angs[f] = 16'sh8000;
      dir_rows.push_back('{'{angs[2], angs[1], angs[0]}, 0, none_q});
      angs[f] = 16'sd12868;   // ~ +pi/2, fold edge
      dir_rows.push_back('{'{angs[2], angs[1], angs[0]}, 0, none_q});
      angs[f] = -16'sd12868;
      dir_rows.push_back('{'{angs[2], angs[1], angs[0]}, 0, none_q});
      angs[f] = 16'sd25736;   // ~ pi: negative trace, this axis dominates
      dir_rows.push_back('{'{angs[2], angs[1], angs[0]}, 0, none_q});
    end
    // all angles at extremes, and ties between diagonals
    dir_rows.push_back('{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 0, none_q});
    dir_rows.push_back('{'{16'sh8000, 16'sh8000, 16'sh8000}, 0, none_q});
    dir_rows.push_back('{'{16'sd25736, 16'sd0, 16'sd25736}, 0, none_q});
    dir_rows.push_back('{'{16'sd0, 16'sd12868, 16'sd0}, 0, none_q});
    dir_rows.push_back('{'{16'sh5555, 16'shAAAA, 16'sh5555}, 0, none_q});
    dir_rows.push_back('{'{16'shAAAA, 16'sh5555, 16'shAAAA}, 0, none_q});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[n]) send_attitude(dir_rows[n].a, dir_rows[n].has_q, dir_rows[n].q);

    for (int n = 0; n < N_RANDOM; n++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        // near the fold or trace boundaries
        a.roll  = 16'($urandom_range(0, 1) ? 25736 : 12868) + 16'($urandom_range(0, 15)) - 16'sd8;
        a.pitch = 16'($urandom);
        a.yaw   = 16'($urandom_range(0, 1) ? -25736 : 25736);
      end else begin
        a = 48'({$urandom, $urandom});
      end
      send_attitude(a, 0, none_q);
      // an occasional long run with no input gaps between beats
      if ($urandom_range(0, 99) == 0) begin
        for (int b = 0; b < 20; b++) begin
          in_tvalid <= 1'b1;
          a = 48'({$urandom, $urandom});
          in_tdata <= a;
          do @(posedge clk); while (!in_tready);
          quat_queue.push_back(attitude_to_quat(a));
        end
      end
    end
    in_tvalid <= 1'b0;

    while (quat_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (n_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
design/euq_pkg.sv
design/euq_cordic.sv
design/euq_root.sv
design/euler_to_quaternion.sv
bench/euler_to_quaternion_tb.sv
